/* rtl/r2y420_pkg.sv */
// Shared widths, coefficients and register codes for the RGB to YUV 4:2:0 converter.
package r2y420_pkg;

  // Field widths.
  localparam int PIX_W        = 8;
  localparam int LUMA_IDX_W   = 24;
  localparam int CHROMA_IDX_W = 22;

  // Configuration port shape.
  localparam int CFG_DW = 13;
  localparam int CFG_IW = 2;

  // Configuration register codes.
  typedef enum logic [CFG_IW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SWAP_ORDER   = 2'd2
  } cfg_reg_t;

  // Register values after reset.
  localparam int   FRAME_WIDTH_RST  = 640;
  localparam int   FRAME_HEIGHT_RST = 480;
  localparam logic SWAP_RST         = 1'b1;

  // Color matrix weights, scaled by 100.
  localparam int Y_R_COEF    = 30;
  localparam int Y_G_COEF    = 59;
  localparam int Y_B_COEF    = 11;
  localparam int U_R_COEF    = 17;
  localparam int U_G_COEF    = 33;
  localparam int U_B_COEF    = 50;
  localparam int V_R_COEF    = 50;
  localparam int V_G_COEF    = 42;
  localparam int V_B_COEF    = 8;
  localparam int CHROMA_BIAS = 12800;

  // Weighted sums stay below 2**15; floor(x / 100) = (x * 20972) >> 21 over that range.
  localparam int SUM_W        = 15;
  localparam int DIV100_MUL   = 20972;
  localparam int DIV100_SHIFT = 21;
  localparam int DIV_PROD_W   = 30;

endpackage

/* rtl/rgb_to_yuv420_converter_top.sv */
// RGB to YUV 4:2:0 pixel stream converter: position counters and a three-stage datapath.
// Throughput: one item per cycle; a stalled output freezes all three stages at once.
// The stages are the input register, the weighted sums and plane index products,
// and the divide-by-100 reciprocal multipliers that feed the output register.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the column and row
// counters and restores a 640x480 frame with the third byte taken as red.
module rgb_to_yuv420_converter_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [r2y420_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [r2y420_pkg::CFG_DW-1:0]         cfg_wdata,
  // Pixel input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [r2y420_pkg::PIX_W-1:0]          in_byte_first,
  input  logic [r2y420_pkg::PIX_W-1:0]          in_byte_middle,
  input  logic [r2y420_pkg::PIX_W-1:0]          in_byte_third,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [r2y420_pkg::PIX_W-1:0]          out_luma,
  output logic [r2y420_pkg::LUMA_IDX_W-1:0]     out_luma_index,
  output logic                                  out_chroma_valid,
  output logic [r2y420_pkg::PIX_W-1:0]          out_blue_diff,
  output logic [r2y420_pkg::PIX_W-1:0]          out_red_diff,
  output logic [r2y420_pkg::CHROMA_IDX_W-1:0]   out_chroma_index,
  output logic                                  out_frame_end
);

  import r2y420_pkg::*;

  // Widths that follow from the frame size limits.
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int IW         = RW + WW + 1;
  localparam int MAXW_EVEN  = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int MAXH_EVEN  = MAX_HEIGHT - (MAX_HEIGHT % 2);
  localparam int RST_W      = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAXW_EVEN : FRAME_WIDTH_RST;
  localparam int RST_H      = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAXH_EVEN : FRAME_HEIGHT_RST;

  // Configuration state, held as effective (even, clamped) sizes.
  logic [WW-1:0] eff_w_r;
  logic [HW-1:0] eff_h_r;
  logic          swap_r;
  logic [CFG_DW-1:0] cfg_even;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;

  // Position counters for the next pixel.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Pipeline control.
  logic adv;
  logic accept;

  // Stage 1: input register.
  logic            s1_valid_r;
  logic [PIX_W-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic [CW-1:0]   s1_col_r;
  logic [RW-1:0]   s1_row_r;
  logic            s1_cvalid_r, s1_last_r;

  // Stage 2: weighted sums and plane indexes.
  logic                    s2_valid_r;
  logic [SUM_W-1:0]        s2_ysum_r, s2_usum_r, s2_vsum_r;
  logic [LUMA_IDX_W-1:0]   s2_luma_idx_r;
  logic [CHROMA_IDX_W-1:0] s2_chroma_idx_r;
  logic                    s2_cvalid_r, s2_last_r;

  // Stage 3: output register.
  logic                    out_valid_r;
  logic [PIX_W-1:0]        out_luma_r, out_blue_r, out_red_r;
  logic [LUMA_IDX_W-1:0]   out_luma_idx_r;
  logic [CHROMA_IDX_W-1:0] out_chroma_idx_r;
  logic                    out_cvalid_r, out_last_r;

  // Combinational helpers for position and arithmetic.
  logic            col_wrap;
  logic [RW:0]     row_pre;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [WW-1:0]   col_inc;
  logic [RW:0]     row_inc;
  logic            cur_last;
  logic [PIX_W-1:0] pix_red, pix_blue;
  logic [15:0]     y_sum, u_sum, v_sum;
  logic [IW-1:0]   luma_full, chroma_full;
  logic [DIV_PROD_W-1:0] y_prod, u_prod, v_prod;

  // Effective size of a written width or height: low bit cleared, kept within 2..limit.
  always_comb begin
    cfg_even = {cfg_wdata[CFG_DW-1:1], 1'b0};
    if (cfg_even < CFG_DW'(2)) begin
      w_clamp = WW'(2);
    end else if (14'(cfg_even) > 14'(MAX_WIDTH)) begin
      w_clamp = WW'(MAXW_EVEN);
    end else begin
      w_clamp = WW'(cfg_even);
    end
    if (cfg_even < CFG_DW'(2)) begin
      h_clamp = HW'(2);
    end else if (14'(cfg_even) > 14'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAXH_EVEN);
    end else begin
      h_clamp = HW'(cfg_even);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(RST_W);
      eff_h_r <= HW'(RST_H);
      swap_r  <= SWAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  eff_w_r <= w_clamp;
        CFG_FRAME_HEIGHT: eff_h_r <= h_clamp;
        CFG_SWAP_ORDER:   swap_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished item waits at a stalled output.
  assign adv      = !out_valid_r || !out_stall;
  assign accept   = in_valid && adv;
  assign in_stall = !adv;

  // Position of the arriving pixel; a size shrunk mid-frame wraps the stale position first.
  always_comb begin
    col_wrap = (WW'(col_r) >= eff_w_r);
    row_pre  = col_wrap ? ({1'b0, row_r} + (RW+1)'(1)) : {1'b0, row_r};
    cur_col  = col_wrap ? '0 : col_r;
    cur_row  = (row_pre >= (RW+1)'(eff_h_r)) ? '0 : row_pre[RW-1:0];
    cur_last = (WW'(cur_col) == eff_w_r - WW'(1)) && (HW'(cur_row) == eff_h_r - HW'(1));

    col_inc = WW'(cur_col) + WW'(1);
    row_inc = {1'b0, cur_row} + (RW+1)'(1);
    if (col_inc >= eff_w_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= (RW+1)'(eff_h_r)) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = cur_row;
    end

    pix_red  = swap_r ? in_byte_third : in_byte_first;
    pix_blue = swap_r ? in_byte_first : in_byte_third;
  end

  // Counters advance with each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Stage 1 payload: colors in red, green, blue order, the pixel's position and its chroma and frame-end flags.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red_r    <= pix_red;
      s1_green_r  <= in_byte_middle;
      s1_blue_r   <= pix_blue;
      s1_col_r    <= cur_col;
      s1_row_r    <= cur_row;
      s1_cvalid_r <= cur_row[0] & cur_col[0];
      s1_last_r   <= cur_last;
    end
  end

  // Weighted sums (all nonnegative and below 2**15) and the plane index products.
  always_comb begin
    y_sum = 16'(Y_R_COEF) * 16'(s1_red_r) + 16'(Y_G_COEF) * 16'(s1_green_r)
          + 16'(Y_B_COEF) * 16'(s1_blue_r);
    u_sum = 16'(U_B_COEF) * 16'(s1_blue_r) + 16'(CHROMA_BIAS)
          - 16'(U_R_COEF) * 16'(s1_red_r) - 16'(U_G_COEF) * 16'(s1_green_r);
    v_sum = 16'(V_R_COEF) * 16'(s1_red_r) + 16'(CHROMA_BIAS)
          - 16'(V_G_COEF) * 16'(s1_green_r) - 16'(V_B_COEF) * 16'(s1_blue_r);
    luma_full   = IW'(s1_row_r) * IW'(eff_w_r) + IW'(s1_col_r);
    chroma_full = IW'(s1_row_r >> 1) * IW'(eff_w_r >> 1) + IW'(s1_col_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ysum_r       <= y_sum[SUM_W-1:0];
      s2_usum_r       <= u_sum[SUM_W-1:0];
      s2_vsum_r       <= v_sum[SUM_W-1:0];
      s2_luma_idx_r   <= LUMA_IDX_W'(luma_full);
      s2_chroma_idx_r <= s1_cvalid_r ? CHROMA_IDX_W'(chroma_full) : '0;
      s2_cvalid_r     <= s1_cvalid_r;
      s2_last_r       <= s1_last_r;
    end
  end

  // Divide by 100 through a reciprocal multiply and shift.
  always_comb begin
    y_prod = DIV_PROD_W'(s2_ysum_r) * DIV_PROD_W'(DIV100_MUL);
    u_prod = DIV_PROD_W'(s2_usum_r) * DIV_PROD_W'(DIV100_MUL);
    v_prod = DIV_PROD_W'(s2_vsum_r) * DIV_PROD_W'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_luma_r       <= PIX_W'(y_prod >> DIV100_SHIFT);
      out_blue_r       <= s2_cvalid_r ? PIX_W'(u_prod >> DIV100_SHIFT) : '0;
      out_red_r        <= s2_cvalid_r ? PIX_W'(v_prod >> DIV100_SHIFT) : '0;
      out_luma_idx_r   <= s2_luma_idx_r;
      out_chroma_idx_r <= s2_chroma_idx_r;
      out_cvalid_r     <= s2_cvalid_r;
      out_last_r       <= s2_last_r;
    end
  end

  // Result channel.
  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_luma_index   = out_luma_idx_r;
  assign out_chroma_valid = out_cvalid_r;
  assign out_blue_diff    = out_blue_r;
  assign out_red_diff     = out_red_r;
  assign out_chroma_index = out_chroma_idx_r;
  assign out_frame_end    = out_last_r;

endmodule

/* rtl/r2y420_checker.sv */
// Port-level checks for the RGB to YUV 4:2:0 converter, bound to its top level.
module r2y420_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [r2y420_pkg::PIX_W-1:0]          out_luma,
  input logic [r2y420_pkg::LUMA_IDX_W-1:0]     out_luma_index,
  input logic                                  out_chroma_valid,
  input logic [r2y420_pkg::PIX_W-1:0]          out_blue_diff,
  input logic [r2y420_pkg::PIX_W-1:0]          out_red_diff,
  input logic [r2y420_pkg::CHROMA_IDX_W-1:0]   out_chroma_index,
  input logic                                  out_frame_end
);

  import r2y420_pkg::*;

  // A reset leaves no result item behind.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present right after reset");

  // A stalled result item holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_luma) && $stable(out_luma_index))
    else $error("stalled result item changed");

  // Chroma fields are zero on pixels that carry no chroma.
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chroma_valid |->
      out_blue_diff == '0 && out_red_diff == '0 && out_chroma_index == '0)
    else $error("chroma fields set on a pixel without chroma");

  // Chroma pixels sit on an odd column of an even-width line, so the luma index is odd.
  a_chroma_odd_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chroma_valid |-> out_luma_index[0])
    else $error("chroma pixel at an even luma index");

  // The last pixel of an even-sized frame closes a 2x2 block.
  a_end_has_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_chroma_valid)
    else $error("frame end without chroma");

endmodule

bind rgb_to_yuv420_converter_top r2y420_checker u_r2y420_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_luma         (out_luma),
  .out_luma_index   (out_luma_index),
  .out_chroma_valid (out_chroma_valid),
  .out_blue_diff    (out_blue_diff),
  .out_red_diff     (out_red_diff),
  .out_chroma_index (out_chroma_index),
  .out_frame_end    (out_frame_end)
);
